// ----- rtl/linear_probe_hash_insert_unit_assert.svh -----
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_unit_assert.svh
// Assertion macros for the linear probing hash insert unit
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_INSERT_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPHI_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LPHI_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lphi_pkg.sv -----
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lphi_pkg;

  // parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned KEY_WIDTH_DEF   = 32;

  // fixed field widths
  localparam int unsigned SIZE_W      = 8;
  localparam int unsigned SLOT_PORT_W = 7;

  // table size after reset
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 8'd128;

  // item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mod_step;
    logic probe_init;
    logic probe_step;
    logic ins_write;
    logic full_out;
    logic rd_issue;
    logic rd_out;
    logic clr_step;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mod_last;
    logic probe_free;
    logic probe_full;
    logic clr_last;
  } dp_sts_t;

endpackage

// ----- rtl/lphi_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphi_ctrl
// Sequencer: clearing pass, key remainder, slot probing and slot reads
// ----------------------------------------------------------------------------
module lphi_ctrl import lphi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    mode_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PINIT,
    ST_PROBE,
    ST_RD_ISSUE,
    ST_RD_DATA
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (mode_i == MODE_READ) ? ST_RD_ISSUE : ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_PINIT;
        end
      end
      ST_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.probe_free) begin
          cmd_o.ins_write = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.probe_full) begin
          cmd_o.full_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      ST_RD_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.rd_out = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register, clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/lphi_dpath.sv -----
// ----------------------------------------------------------------------------
// lphi_dpath
// Datapath: size register, bit-serial remainder, probe pointers, slot memory
// ----------------------------------------------------------------------------
module lphi_dpath import lphi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   table_size_we_i,
  input  logic [SIZE_W-1:0]      table_size_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [SLOT_PORT_W-1:0] read_slot_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  output logic                   done_o,
  output logic                   status_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic [KEY_WIDTH-1:0]   slot_key_o,
  output logic                   occupied_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CMP_W  = ((SLOT_W > SIZE_W) ? SLOT_W : SIZE_W) + 1;
  localparam int unsigned BIT_W  = $clog2(KEY_WIDTH);

  typedef struct packed {
    logic                 occ;
    logic [KEY_WIDTH-1:0] key;
  } entry_t;

  logic [SIZE_W-1:0]      size_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [SLOT_PORT_W-1:0] rslot_q;
  logic [CMP_W-1:0]       rem_q, rem_d, rem_sh;
  logic [BIT_W-1:0]       bit_q;
  logic [SLOT_W-1:0]      iptr_q, iptr_nxt, chk_ptr_q;
  logic                   chk_vld_q;
  logic [CMP_W-1:0]       n_q;
  logic [CMP_W-1:0]       eff, size_ext, iptr_inc, rslot_ext, chk_ext;
  logic                   rd_in_range;
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q, wr_data;
  logic [SLOT_W-1:0]      rd_addr, wr_addr;
  logic                   mem_we, mem_re;
  logic                   done_q, status_q, occ_q;
  logic [SLOT_PORT_W-1:0] slot_q;
  logic [KEY_WIDTH-1:0]   slot_key_q;

  // table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= TABLE_SIZE_RST;
    end else if (table_size_we_i) begin
      size_q <= table_size_i;
    end
  end

  // effective size, clamped to 1..TABLE_DEPTH
  always_comb begin
    size_ext = CMP_W'(size_q);
    if (size_q == '0) begin
      eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(TABLE_DEPTH)) begin
      eff = CMP_W'(TABLE_DEPTH);
    end else begin
      eff = size_ext;
    end
  end

  // one restoring remainder step per cycle, key msb first
  assign rem_sh = {rem_q[CMP_W-2:0], key_q[bit_q]};
  assign rem_d  = (rem_sh >= eff) ? (rem_sh - eff) : rem_sh;

  // probe pointer wraps at the effective size
  assign iptr_inc = CMP_W'(iptr_q) + CMP_W'(1);
  assign iptr_nxt = (iptr_inc == eff) ? '0 : iptr_inc[SLOT_W-1:0];

  // read slot range check
  assign rslot_ext   = CMP_W'(rslot_q);
  assign rd_in_range = (rslot_ext < eff);
  assign chk_ext     = CMP_W'(chk_ptr_q);

  // status toward the controller
  assign sts_o.mod_last   = (bit_q == '0);
  assign sts_o.probe_free = chk_vld_q & ~rd_q.occ;
  assign sts_o.probe_full = chk_vld_q & rd_q.occ & ((n_q + CMP_W'(1)) == eff);
  assign sts_o.clr_last   = (iptr_q == SLOT_W'(TABLE_DEPTH - 1));

  // item capture and remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= key_i;
      rslot_q <= read_slot_i;
      rem_q   <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
    end
  end

  // bit counter of the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.load) begin
      bit_q <= BIT_W'(KEY_WIDTH - 1);
    end else if (cmd_i.mod_step) begin
      bit_q <= bit_q - BIT_W'(1);
    end
  end

  // issue pointer, doubles as clear address; probe check stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iptr_q    <= '0;
      chk_vld_q <= 1'b0;
      n_q       <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        iptr_q <= iptr_q + SLOT_W'(1);
      end else if (cmd_i.probe_init) begin
        iptr_q <= rem_q[SLOT_W-1:0];
      end else if (cmd_i.probe_step) begin
        iptr_q <= iptr_nxt;
      end
      if (cmd_i.probe_init) begin
        chk_vld_q <= 1'b0;
        n_q       <= '0;
      end else if (cmd_i.probe_step) begin
        chk_vld_q <= 1'b1;
        if (chk_vld_q && rd_q.occ) begin
          n_q <= n_q + CMP_W'(1);
        end
      end
    end
  end

  // slot address of the data coming back from memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_step) begin
      chk_ptr_q <= iptr_q;
    end
  end

  // slot memory port control
  assign mem_we  = cmd_i.clr_step | cmd_i.ins_write;
  assign wr_addr = cmd_i.clr_step ? iptr_q : chk_ptr_q;
  assign wr_data = cmd_i.clr_step ? '0 : {1'b1, key_q};
  assign mem_re  = cmd_i.rd_issue | cmd_i.probe_step;
  assign rd_addr = cmd_i.rd_issue ? rslot_ext[SLOT_W-1:0] : iptr_q;

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.ins_write | cmd_i.full_out | cmd_i.rd_out;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write) begin
      status_q   <= STATUS_DONE;
      slot_q     <= chk_ext[SLOT_PORT_W-1:0];
      slot_key_q <= key_q;
      occ_q      <= 1'b1;
    end else if (cmd_i.full_out) begin
      status_q   <= STATUS_FULL;
      slot_q     <= '0;
      slot_key_q <= '0;
      occ_q      <= 1'b0;
    end else if (cmd_i.rd_out) begin
      status_q   <= STATUS_DONE;
      slot_q     <= rslot_q;
      slot_key_q <= (rd_in_range && rd_q.occ) ? rd_q.key : '0;
      occ_q      <= rd_in_range & rd_q.occ;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign slot_o     = slot_q;
  assign slot_key_o = slot_key_q;
  assign occupied_o = occ_q;

endmodule

// ----- rtl/linear_probe_hash_insert_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_unit: linear probing hash table, insert and slot read
// Insert: remainder, then probing; read: one slot fetch; a result strobe follows.
// Throughput: one item at a time; start is taken only while busy is low.
// Reset: clears all TABLE_DEPTH slots with busy high; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_insert_unit_assert.svh"

module linear_probe_hash_insert_unit import lphi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   table_size_we_i,
  input  logic [SIZE_W-1:0]      table_size_i,
  input  logic                   start,
  input  logic                   mode_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [SLOT_PORT_W-1:0] read_slot_i,
  output logic                   busy,
  output logic                   done_o,
  output logic                   status_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic [KEY_WIDTH-1:0]   slot_key_o,
  output logic                   occupied_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  lphi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath with slot memory
  lphi_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .table_size_we_i (table_size_we_i),
    .table_size_i    (table_size_i),
    .key_i           (key_i),
    .read_slot_i     (read_slot_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .slot_key_o      (slot_key_o),
    .occupied_o      (occupied_o)
  );

  // checks
  `LPHI_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LPHI_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while busy")
  `LPHI_ASSERT_NXT(a_result_strobe,
                   cmd.ins_write || cmd.full_out || cmd.rd_out,
                   done_o, "result lost")
  `LPHI_ASSERT_IMP(a_full_zero, done_o && status_o == STATUS_FULL,
                   !occupied_o && slot_o == '0 && slot_key_o == '0,
                   "full result not cleared")

endmodule

// ----- tb/tb_linear_probe_hash_insert_unit.sv -----
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_insert_unit
// Self-checking bench for the linear probing hash insert unit. A directed
// table covers empty reads, key extremes, wrap-around probing, size
// saturation, full table and out-of-range reads. Random phases then step the
// table size through small, large and saturating values, mixing inserts and
// slot reads. Results are checked against an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_insert_unit import lphi_pkg::*; ();

  localparam int unsigned DEPTH      = TABLE_DEPTH_DEF;
  localparam int unsigned NUM_PHASES = 17;
  localparam int unsigned PHASE_LEN  = 78;
  localparam int PHASE_SIZES [NUM_PHASES] =
    '{2, 3, 5, 8, 0, 12, 18, 255, 26, 36, 1, 48, 64, 80, 100, 128, 200};
  localparam int unsigned NUM_ROWS   = 22;

  typedef struct packed {
    logic                   status;
    logic [SLOT_PORT_W-1:0] slot;
    logic [31:0]            slot_key;
    logic                   occupied;
  } hash_result_t;

  typedef struct packed {
    logic                   set_size;
    logic [SIZE_W-1:0]      size;
    logic                   mode;
    logic [31:0]            key;
    logic [SLOT_PORT_W-1:0] rslot;
    logic                   hand_checked;
    hash_result_t           want;
  } probe_row_t;

  // directed rows: optional size write, then one item
  localparam probe_row_t ROWS [NUM_ROWS] = '{
    // empty table right after reset
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd0,   1'b1, '{STATUS_DONE, 7'd0,   32'h0, 1'b0}},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd127, 1'b1, '{STATUS_DONE, 7'd127, 32'h0, 1'b0}},
    // key extremes land on the first and last slot
    '{1'b0, 8'd0,   MODE_INSERT, 32'h0,        7'd0,   1'b1, '{STATUS_DONE, 7'd0,   32'h0, 1'b1}},
    '{1'b0, 8'd0,   MODE_INSERT, 32'hFFFFFFFF, 7'd0,   1'b1,
      '{STATUS_DONE, 7'd127, 32'hFFFFFFFF, 1'b1}},
    // collisions, one wrapping past the last slot
    '{1'b0, 8'd0,   MODE_INSERT, 32'd128,      7'd0,   1'b0, '0},
    '{1'b0, 8'd0,   MODE_INSERT, 32'd255,      7'd0,   1'b0, '0},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd127, 1'b0, '0},
    // ignored fields carry junk
    '{1'b0, 8'd0,   MODE_READ,   32'hFFFFFFFF, 7'd1,   1'b0, '0},
    '{1'b0, 8'd0,   MODE_INSERT, 32'h80000000, 7'd127, 1'b0, '0},
    // size zero acts as one slot, already taken
    '{1'b1, 8'd0,   MODE_INSERT, 32'd5,        7'd0,   1'b1, '{STATUS_FULL, 7'd0,   32'h0, 1'b0}},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd1,   1'b1, '{STATUS_DONE, 7'd1,   32'h0, 1'b0}},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd0,   1'b0, '0},
    '{1'b1, 8'd1,   MODE_INSERT, 32'hFFFFFFFF, 7'd0,   1'b1, '{STATUS_FULL, 7'd0,   32'h0, 1'b0}},
    // oversize register saturates to the full depth
    '{1'b1, 8'd255, MODE_INSERT, 32'hAAAAAAAA, 7'd0,   1'b0, '0},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd127, 1'b0, '0},
    // four slots, all taken
    '{1'b1, 8'd4,   MODE_INSERT, 32'd7,        7'd0,   1'b1, '{STATUS_FULL, 7'd0,   32'h0, 1'b0}},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd4,   1'b1, '{STATUS_DONE, 7'd4,   32'h0, 1'b0}},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd3,   1'b0, '0},
    '{1'b1, 8'd6,   MODE_INSERT, 32'd3,        7'd0,   1'b0, '0},
    '{1'b0, 8'd0,   MODE_INSERT, 32'h55555555, 7'd0,   1'b0, '0},
    // regrown table keeps slots written before the shrink
    '{1'b1, 8'd128, MODE_READ,   32'h0,        7'd42,  1'b0, '0},
    '{1'b0, 8'd0,   MODE_READ,   32'h0,        7'd127, 1'b0, '0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   table_size_we_i;
  logic [SIZE_W-1:0]      table_size_i;
  logic                   start;
  logic                   mode_i;
  logic [31:0]            key_i;
  logic [SLOT_PORT_W-1:0] read_slot_i;
  logic                   busy;
  logic                   done_o;
  logic                   status_o;
  logic [SLOT_PORT_W-1:0] slot_o;
  logic [31:0]            slot_key_o;
  logic                   occupied_o;

  // model of the table
  logic [SIZE_W-1:0] size_reg;
  logic [31:0]       slot_keys [DEPTH];
  logic              slot_used [DEPTH];

  hash_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  burst_left;

  linear_probe_hash_insert_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .table_size_we_i (table_size_we_i),
    .table_size_i    (table_size_i),
    .start           (start),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .read_slot_i     (read_slot_i),
    .busy            (busy),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .slot_key_o      (slot_key_o),
    .occupied_o      (occupied_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned live_size();
    if (size_reg == 0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // insert or read against the model table
  function automatic hash_result_t hash_apply(input logic mode, input logic [31:0] key,
                                              input logic [SLOT_PORT_W-1:0] rslot);
    hash_result_t r;
    int unsigned  sz;
    int unsigned  pos;
    r  = '{STATUS_DONE, '0, '0, 1'b0};
    sz = live_size();
    if (mode == MODE_INSERT) begin
      pos = key % sz;
      for (int unsigned n = 0; n < sz; n++) begin
        if (!slot_used[pos]) begin
          slot_keys[pos] = key;
          slot_used[pos] = 1'b1;
          r.slot     = pos[SLOT_PORT_W-1:0];
          r.slot_key = key;
          r.occupied = 1'b1;
          return r;
        end
        pos = (pos + 1 >= sz) ? 0 : pos + 1;
      end
      r.status = STATUS_FULL;
      return r;
    end
    r.slot = rslot;
    if (rslot < sz && slot_used[rslot]) begin
      r.slot_key = slot_keys[rslot];
      r.occupied = 1'b1;
    end
    return r;
  endfunction

  // drive one item after an optional gap, then wait for its transfer
  task automatic send_item(input logic mode, input logic [31:0] key,
                           input logic [SLOT_PORT_W-1:0] rslot, input bit hand_checked,
                           input hash_result_t want);
    int unsigned  gap;
    hash_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      gap = 0;
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       <= 1'b1;
    mode_i      <= mode;
    key_i       <= key;
    read_slot_i <= rslot;
    do @(posedge clk_i); while (busy);
    predicted = hash_apply(mode, key, rslot);
    pending_results.push_back(hand_checked ? want : predicted);
  endtask

  // write the size register once the block is idle
  task automatic set_table_size(input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    table_size_we_i <= 1'b1;
    table_size_i    <= value;
    @(negedge clk_i);
    table_size_we_i <= 1'b0;
    size_reg = value;
  endtask

  // result check on every strobe
  always @(posedge clk_i) begin : check_results
    hash_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, slot %0d", slot_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (slot_o !== want.slot)
          flag_mismatch($sformatf("slot got %0d want %0d", slot_o, want.slot));
        if (slot_key_o !== want.slot_key)
          flag_mismatch($sformatf("slot_key got %h want %h", slot_key_o, want.slot_key));
        if (occupied_o !== want.occupied)
          flag_mismatch($sformatf("occupied got %0d want %0d", occupied_o, want.occupied));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned            sz;
    logic                   mode;
    logic [31:0]            key;
    logic [SLOT_PORT_W-1:0] rslot;
    int unsigned            pick;

    rst_ni          = 1'b0;
    table_size_we_i = 1'b0;
    table_size_i    = '0;
    start           = 1'b0;
    mode_i          = MODE_INSERT;
    key_i           = '0;
    read_slot_i     = '0;
    mismatches      = 0;
    burst_left      = 0;
    size_reg        = TABLE_SIZE_RST;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_keys[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (ROWS[r].set_size) set_table_size(ROWS[r].size);
      send_item(ROWS[r].mode, ROWS[r].key, ROWS[r].rslot, ROWS[r].hand_checked, ROWS[r].want);
    end

    // random phases over a range of table sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_table_size(SIZE_W'(PHASE_SIZES[p]));
      sz = live_size();
      for (int i = 0; i < PHASE_LEN; i++) begin
        mode  = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_READ;
        key   = $urandom();
        rslot = SLOT_PORT_W'($urandom_range(0, DEPTH - 1));
        pick  = $urandom_range(0, 9);
        if (mode == MODE_INSERT) begin
          // random, small and high keys
          if (pick < 2) key = $urandom_range(0, 2 * sz);
          else if (pick < 4) key = 32'hFFFFFF00 | $urandom_range(0, 255);
        end else begin
          // mostly inside the table, some beyond it
          if (pick < 8) rslot = SLOT_PORT_W'($urandom_range(0, sz - 1));
          else if (pick == 8) rslot = SLOT_PORT_W'(DEPTH - 1);
        end
        send_item(mode, key, rslot, 1'b0, '0);
      end
    end

    // drain
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
